// ----- hw/rtl/dti_pkg.sv -----
// Shared types, constants and codes of the decision tree inference core.
`default_nettype none

package dti_pkg;

  // Table sizes and walk bound.
  localparam int unsigned MaxNodes    = 256;
  localparam int unsigned NumFeatures = 32;
  localparam int unsigned MaxDepth    = 32;

  localparam int unsigned NodeAw = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
  localparam int unsigned FeatAw = (NumFeatures > 1) ? $clog2(NumFeatures) : 1;
  localparam int unsigned StepW  = $clog2(MaxDepth + 1);

  // Field widths of the words.
  localparam int unsigned AddrW  = 8;
  localparam int unsigned FIdxW  = 5;
  localparam int unsigned ValueW = 16;

  // Item kinds.
  localparam logic KindNode   = 1'b0;
  localparam logic KindSample = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic [AddrW-1:0]         node_addr;
    logic [FIdxW-1:0]         split_feature;
    logic signed [ValueW-1:0] split_threshold;
    logic [AddrW-1:0]         left_child;
    logic [AddrW-1:0]         right_child;
    logic                     is_leaf;
    logic signed [ValueW-1:0] leaf_value;
    logic [FIdxW-1:0]         feature_addr;
    logic signed [ValueW-1:0] sample_value;
    logic                     last_feature;
  } dti_in_t;

  typedef struct packed {
    logic signed [ValueW-1:0] result_value;
    logic                     walk_error;
  } dti_out_t;

  // One entry of the node table.
  typedef struct packed {
    logic [FIdxW-1:0]         split_feature;
    logic signed [ValueW-1:0] split_threshold;
    logic [AddrW-1:0]         left_child;
    logic [AddrW-1:0]         right_child;
    logic                     is_leaf;
    logic signed [ValueW-1:0] leaf_value;
  } dti_node_t;

  localparam int unsigned NodeW = $bits(dti_node_t);

  // Write and read requests toward the two memories.
  typedef struct packed {
    logic              we;
    logic [NodeAw-1:0] addr;
    dti_node_t         data;
  } dti_node_wr_t;

  typedef struct packed {
    logic              re;
    logic [NodeAw-1:0] addr;
  } dti_node_rd_t;

  typedef struct packed {
    logic              we;
    logic [FeatAw-1:0] addr;
    logic [ValueW-1:0] data;
  } dti_feat_wr_t;

  typedef struct packed {
    logic              re;
    logic [FeatAw-1:0] addr;
  } dti_feat_rd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NODE,
    ST_FEAT
  } dti_state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/decision_tree_inference_core.sv -----
// Top level of the decision tree inference core.
//
//   channel   dir   payload      handshake
//   -------   ---   ----------   ---------------------------
//   in        in    dti_in_t     in_valid_i / in_ready_o
//   out       out   dti_out_t    out_valid_o / out_ready_i
//
// A node write or a sample that does not end a vector is taken while idle and starts no walk.
// A sample that ends a vector starts a walk from the root; each internal node
// costs one node read and one feature read, and the input is held off until
// the walk ends at a leaf or on an error and its result word is registered.
// Reset clears the sequencer and the output valid; the memories keep their contents.
// While an earlier result word waits, a finished walk stalls on its last step.
`default_nettype none

module decision_tree_inference_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire dti_pkg::dti_in_t in_word_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output dti_pkg::dti_out_t     out_word_o
);

  import dti_pkg::*;

  dti_node_wr_t      node_wr;
  dti_node_rd_t      node_rd;
  dti_feat_wr_t      feat_wr;
  dti_feat_rd_t      feat_rd;
  logic [NodeW-1:0]  node_rdata;
  logic [ValueW-1:0] feat_rdata;

  // The sequencer owns every handshake and every memory port.
  dti_walker u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o),
    .node_wr_o    (node_wr),
    .node_rd_o    (node_rd),
    .node_rdata_i (dti_node_t'(node_rdata)),
    .feat_wr_o    (feat_wr),
    .feat_rd_o    (feat_rd),
    .feat_rdata_i (feat_rdata)
  );

  // Tree table: one packed node entry per address.
  dti_ram #(
    .Depth (MaxNodes),
    .Width (NodeW)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_wr.we),
    .waddr_i (node_wr.addr),
    .wdata_i (node_wr.data),
    .re_i    (node_rd.re),
    .raddr_i (node_rd.addr),
    .rdata_o (node_rdata)
  );

  // Feature buffer: one sample per feature index.
  dti_ram #(
    .Depth (NumFeatures),
    .Width (ValueW)
  ) u_feat_ram (
    .clk_i   (clk_i),
    .we_i    (feat_wr.we),
    .waddr_i (feat_wr.addr),
    .wdata_i (feat_wr.data),
    .re_i    (feat_rd.re),
    .raddr_i (feat_rd.addr),
    .rdata_o (feat_rdata)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/dti_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module dti_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 54,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds its value until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dti_walker.sv -----
// Sequencer that loads the memories, walks the tree and holds the result word.
`default_nettype none

module dti_walker (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire dti_pkg::dti_in_t in_word_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output dti_pkg::dti_out_t     out_word_o,
  output dti_pkg::dti_node_wr_t node_wr_o,
  output dti_pkg::dti_node_rd_t node_rd_o,
  input  wire dti_pkg::dti_node_t node_rdata_i,
  output dti_pkg::dti_feat_wr_t feat_wr_o,
  output dti_pkg::dti_feat_rd_t feat_rd_o,
  input  wire logic [dti_pkg::ValueW-1:0] feat_rdata_i
);

  import dti_pkg::*;

  dti_state_e state_q, state_d;

  logic [StepW-1:0]  steps_q, steps_d;
  logic signed [ValueW-1:0] thr_q;
  logic [AddrW-1:0]  left_q, right_q;
  logic              capture;

  logic              out_valid_q;
  dti_out_t          out_word_q;
  logic              out_free;
  logic              fin_req;
  dti_out_t          fin_word;

  logic              node_in_range;
  logic              feat_in_range;
  logic              split_in_range;
  logic              depth_hit;
  logic              go_left;
  logic [AddrW-1:0]  next_node;
  logic              next_in_range;

  assign out_free = !out_valid_q || out_ready_i;

  assign node_in_range  = 32'(in_word_i.node_addr) < MaxNodes;
  assign feat_in_range  = 32'(in_word_i.feature_addr) < NumFeatures;
  assign split_in_range = 32'(node_rdata_i.split_feature) < NumFeatures;
  assign depth_hit      = steps_q >= StepW'(MaxDepth);
  assign go_left        = $signed(feat_rdata_i) <= thr_q;
  assign next_node      = go_left ? left_q : right_q;
  assign next_in_range  = 32'(next_node) < MaxNodes;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_word_i.kind == KindSample && in_word_i.last_feature) begin
          state_d = ST_NODE;
        end
      end
      ST_NODE: begin
        if (node_rdata_i.is_leaf || depth_hit || !split_in_range) begin
          if (out_free) begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_FEAT;
        end
      end
      ST_FEAT: begin
        if (!next_in_range) begin
          if (out_free) begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_NODE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and memory requests.
  always_comb begin
    in_ready_o = 1'b0;
    node_wr_o  = '0;
    node_rd_o  = '0;
    feat_wr_o  = '0;
    feat_rd_o  = '0;
    fin_req    = 1'b0;
    fin_word   = '0;
    capture    = 1'b0;
    steps_d    = steps_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_word_i.kind == KindNode) begin
            node_wr_o.we                   = node_in_range;
            node_wr_o.addr                 = in_word_i.node_addr[NodeAw-1:0];
            node_wr_o.data.split_feature   = in_word_i.split_feature;
            node_wr_o.data.split_threshold = in_word_i.split_threshold;
            node_wr_o.data.left_child      = in_word_i.left_child;
            node_wr_o.data.right_child     = in_word_i.right_child;
            node_wr_o.data.is_leaf         = in_word_i.is_leaf;
            node_wr_o.data.leaf_value      = in_word_i.leaf_value;
          end else begin
            feat_wr_o.we   = feat_in_range;
            feat_wr_o.addr = in_word_i.feature_addr[FeatAw-1:0];
            feat_wr_o.data = in_word_i.sample_value;
            if (in_word_i.last_feature) begin
              // The walk always starts at the root.
              node_rd_o.re   = 1'b1;
              node_rd_o.addr = '0;
              steps_d        = '0;
            end
          end
        end
      end
      ST_NODE: begin
        if (node_rdata_i.is_leaf) begin
          fin_req               = 1'b1;
          fin_word.result_value = node_rdata_i.leaf_value;
          fin_word.walk_error   = 1'b0;
        end else if (depth_hit || !split_in_range) begin
          fin_req             = 1'b1;
          fin_word.walk_error = 1'b1;
        end else begin
          feat_rd_o.re   = 1'b1;
          feat_rd_o.addr = node_rdata_i.split_feature[FeatAw-1:0];
          capture        = 1'b1;
        end
      end
      ST_FEAT: begin
        if (!next_in_range) begin
          fin_req             = 1'b1;
          fin_word.walk_error = 1'b1;
        end else begin
          node_rd_o.re   = 1'b1;
          node_rd_o.addr = next_node[NodeAw-1:0];
          steps_d        = steps_q + StepW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      steps_q <= steps_d;
      if (fin_req && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      thr_q   <= node_rdata_i.split_threshold;
      left_q  <= node_rdata_i.left_child;
      right_q <= node_rdata_i.right_child;
    end
    if (fin_req && out_free) begin
      out_word_q <= fin_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

// ----- hw/rtl/dti_checker.sv -----
// Port-level checks of the decision tree inference core and their binding.
`default_nettype none

module dti_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire dti_pkg::dti_in_t in_word_i,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire dti_pkg::dti_out_t out_word_o
);

  import dti_pkg::*;

  // A result word waiting for the sink keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
  else $error("result word changed while stalled");

  // A failed walk reports a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.walk_error |-> out_word_o.result_value == '0)
  else $error("walk error with nonzero value");

  // The word that ends a vector starts a walk, so input is held off next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_word_i.kind == KindSample && in_word_i.last_feature
    |=> !in_ready_o)
  else $error("input accepted during a walk");

  // A node write never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_word_i.kind == KindNode |=> !$rose(out_valid_o))
  else $error("result after a node write");

endmodule

bind decision_tree_inference_core dti_checker u_dti_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire
